@@ hdl/afb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package afb_pkg;

  // Operand and result width.
  localparam int DATA_W = 16;

  // Operation codes carried in the kind field.
  typedef enum logic [3:0] {
    KIND_ADD  = 4'd0,
    KIND_ADC  = 4'd1,
    KIND_SUB  = 4'd2,
    KIND_SBC  = 4'd3,
    KIND_RSUB = 4'd4,
    KIND_AND  = 4'd5,
    KIND_OR   = 4'd6,
    KIND_XOR  = 4'd7,
    KIND_TEST = 4'd8
  } kind_t;

  // Branch condition codes. Codes 13 to 15 are never true.
  typedef enum logic [3:0] {
    COND_AL   = 4'd0,
    COND_HI   = 4'd1,
    COND_LS   = 4'd2,
    COND_HS   = 4'd3,
    COND_LO   = 4'd4,
    COND_EQ   = 4'd5,
    COND_NE   = 4'd6,
    COND_GE   = 4'd7,
    COND_LT   = 4'd8,
    COND_GT   = 4'd9,
    COND_LE   = 4'd10,
    COND_AL_B = 4'd11,
    COND_AL_C = 4'd12
  } cond_t;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  // One request as held in the input register.
  typedef struct packed {
    logic [3:0]        kind;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [3:0]        condition;
    logic              clear_carry;
  } req_t;

endpackage

`default_nettype wire

@@ hdl/afb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface afb_in_if;
  import afb_pkg::*;

  logic              valid;
  logic              ready;
  logic [3:0]        kind;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;
  logic [3:0]        condition;
  logic              clear_carry;

  modport source (output valid, kind, operand_a, operand_b, condition, clear_carry,
                  input ready);
  modport sink (input valid, kind, operand_a, operand_b, condition, clear_carry,
                output ready);
endinterface

interface afb_out_if;
  import afb_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result;
  logic              neg_flag;
  logic              zero_flag;
  logic              ovf_flag;
  logic              carry_flag;
  logic              taken;

  modport source (output valid, result, neg_flag, zero_flag, ovf_flag, carry_flag, taken,
                  input ready);
  modport sink (input valid, result, neg_flag, zero_flag, ovf_flag, carry_flag, taken,
                output ready);
endinterface

`default_nettype wire

@@ hdl/afb_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afb_alu (
  input  wire logic [3:0]                 kind,
  input  wire logic [afb_pkg::DATA_W-1:0] operand_a,
  input  wire logic [afb_pkg::DATA_W-1:0] operand_b,
  input  wire logic                       clear_carry,
  input  wire afb_pkg::flags_t            flags_in,
  output logic [afb_pkg::DATA_W-1:0]      result,
  output afb_pkg::flags_t                 flags_out
);
  import afb_pkg::*;

  logic              is_alu;
  logic              is_arith;
  logic              is_sub;
  logic              c_in;
  logic              cin;
  logic [DATA_W-1:0] b_eff;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] r;
  logic              c_new;

  always_comb begin
    is_alu   = (kind <= KIND_XOR);
    is_arith = (kind <= KIND_SBC);
    is_sub   = (kind == KIND_SUB) || (kind == KIND_SBC);
    c_in     = clear_carry ? 1'b0 : flags_in.c;
    b_eff    = is_sub ? ~operand_b : operand_b;

    // For subtraction the carry-in is the inverse of the borrow.
    case (kind)
      KIND_ADD: cin = 1'b0;
      KIND_ADC: cin = c_in;
      KIND_SUB: cin = 1'b1;
      KIND_SBC: cin = ~c_in;
      default:  cin = 1'b0;
    endcase

    sum = {1'b0, operand_a} + {1'b0, b_eff} + {{DATA_W{1'b0}}, cin};

    case (kind)
      KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBC: r = sum[DATA_W-1:0];
      KIND_RSUB: r = operand_b - operand_a;
      KIND_AND:  r = operand_a & operand_b;
      KIND_OR:   r = operand_a | operand_b;
      KIND_XOR:  r = operand_a ^ operand_b;
      default:   r = '0;
    endcase

    // C is a borrow after subtraction and the carry out after addition; the other ops keep the incoming C.
    c_new = is_arith ? (sum[DATA_W] ^ is_sub) : c_in;

    result = r;
    if (is_alu) begin
      flags_out.n = r[DATA_W-1];
      flags_out.z = (r == '0);
      flags_out.v = (operand_a[DATA_W-1] ^ r[DATA_W-1]) & (b_eff[DATA_W-1] ^ r[DATA_W-1]);
      flags_out.c = c_new;
    end else begin
      flags_out = flags_in;
    end
  end

endmodule

`default_nettype wire

@@ hdl/afb_cond.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afb_cond (
  input  wire logic             is_test,
  input  wire logic [3:0]       condition,
  input  wire afb_pkg::flags_t  flags,
  output logic                  taken
);
  import afb_pkg::*;

  logic hold;

  always_comb begin
    case (condition)
      COND_AL:   hold = 1'b1;
      COND_HI:   hold = ~flags.c & ~flags.z;
      COND_LS:   hold = flags.c | flags.z;
      COND_HS:   hold = ~flags.c;
      COND_LO:   hold = flags.c;
      COND_EQ:   hold = flags.z;
      COND_NE:   hold = ~flags.z;
      COND_GE:   hold = (flags.n == flags.v);
      COND_LT:   hold = (flags.n != flags.v);
      COND_GT:   hold = ~flags.z & (flags.n == flags.v);
      COND_LE:   hold = flags.z | (flags.n != flags.v);
      COND_AL_B: hold = 1'b1;
      COND_AL_C: hold = 1'b1;
      default:   hold = 1'b0;
    endcase
    taken = is_test & hold;
  end

endmodule

`default_nettype wire

@@ hdl/alu_with_flags_and_branch_test.sv @@
`timescale 1ns / 1ps
`default_nettype none

// ALU with N, Z, V and C flags and a branch condition test. Each request carries an
// operation (add, add with carry, subtract, subtract with borrow, reverse subtract, and,
// or, xor, or a condition test) and produces exactly one response with the 16-bit result,
// the flags as they stand after the request, and the taken bit of a condition test. The
// block sustains one request per clock while the output is not stalled: a request is
// latched into an input register, evaluated by the adder, the logic ops and the flag
// logic on the way to the response register, and the flags update in that same cycle,
// so the next request already sees them. Subtraction inverts operand b and leaves C
// meaning borrow; reverse subtract and the logic ops keep the incoming C, which
// clear_carry may zero first. A condition test and the unused kind codes return a zero
// result and leave the flags untouched. Flags reset to zero.

module alu_with_flags_and_branch_test (
  input  wire logic clk,
  input  wire logic rst_n,
  afb_in_if.sink    in_if,
  afb_out_if.source out_if
);
  import afb_pkg::*;

  // Input register.
  logic req_valid_r;
  logic req_valid_nxt;
  req_t req_r;

  // Response register and the flag state.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_result_r;
  logic              out_taken_r;
  flags_t            flags_r;

  logic              advance;
  logic              in_take;
  logic [DATA_W-1:0] alu_result;
  flags_t            alu_flags;
  logic              is_test;
  logic              test_taken;

  // A held request moves to the response register whenever that register is free
  // or is being emptied this cycle.
  assign advance  = req_valid_r && (!out_valid_r || out_if.ready);
  assign in_take  = in_if.valid && in_if.ready;
  assign in_if.ready = !req_valid_r || advance;

  assign is_test = (req_r.kind == KIND_TEST);

  afb_alu u_alu (
    .kind        (req_r.kind),
    .operand_a   (req_r.operand_a),
    .operand_b   (req_r.operand_b),
    .clear_carry (req_r.clear_carry),
    .flags_in    (flags_r),
    .result      (alu_result),
    .flags_out   (alu_flags)
  );

  afb_cond u_cond (
    .is_test   (is_test),
    .condition (req_r.condition),
    .flags     (flags_r),
    .taken     (test_taken)
  );

  always_comb begin
    req_valid_nxt = in_take || (req_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        flags_r <= alu_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.kind        <= in_if.kind;
      req_r.operand_a   <= in_if.operand_a;
      req_r.operand_b   <= in_if.operand_b;
      req_r.condition   <= in_if.condition;
      req_r.clear_carry <= in_if.clear_carry;
    end
    if (advance) begin
      out_result_r <= alu_result;
      out_taken_r  <= test_taken;
    end
  end

  // The flags only change when a response is loaded, so the live flag register always
  // equals the flags after the request now shown at the output.
  assign out_if.valid      = out_valid_r;
  assign out_if.result     = out_result_r;
  assign out_if.neg_flag   = flags_r.n;
  assign out_if.zero_flag  = flags_r.z;
  assign out_if.ovf_flag   = flags_r.v;
  assign out_if.carry_flag = flags_r.c;
  assign out_if.taken      = out_taken_r;

  // A condition test must not disturb the flags.
  a_test_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_test) |=> (flags_r == $past(flags_r)))
    else $error("condition test changed the flags");

  // After an ALU op the zero flag agrees with the delivered result.
  a_zero_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (req_r.kind <= KIND_XOR)) |=> (out_if.zero_flag == (out_if.result == '0)))
    else $error("zero flag disagrees with result");

  // A taken response comes only from a test, whose result is zero.
  a_taken_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_taken_r) |-> (out_result_r == '0))
    else $error("taken response with nonzero result");

  // Nothing is shown as valid in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !req_valid_r))
    else $error("valid state survived reset");

endmodule

`default_nettype wire

@@ test/tb_alu_with_flags_and_branch_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the flag-keeping ALU. A driver process offers requests from a
// queue that the stimulus process fills, and a monitor process checks every response
// against a predictor that runs at the moment each request is accepted. Both sides
// idle at random, and once the monitor holds off long enough to back the block up.
module tb_alu_with_flags_and_branch_test;
  import afb_pkg::*;

  // Kind codes that the block treats as no operation.
  localparam logic [3:0] KIND_NOP_LO = 4'd9;
  localparam logic [3:0] KIND_NOP_HI = 4'd15;
  // Condition codes past the named ones are never true.
  localparam logic [3:0] COND_NEVER_LO = 4'd13;
  localparam logic [3:0] COND_NEVER_HI = 4'd15;

  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 8;       // extra wait after the last expected response has arrived
  localparam int IDLE_LIMIT   = 3000;    // far beyond the longest stall the bench makes
  localparam int HOLD_AT      = 500;     // response count that starts the long hold-off
  localparam int HOLD_LEN     = 300;
  localparam int PHASE_ITEMS  = 320;

  // One response as the block should produce it.
  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              n;
    logic              z;
    logic              v;
    logic              c;
    logic              taken;
  } alu_out_t;

  logic clk = 1'b0;
  logic rst_n;

  afb_in_if  in_if ();
  afb_out_if out_if ();

  alu_with_flags_and_branch_test DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t     req_q[$];       // requests waiting to be offered
  alu_out_t expected_q[$];  // predicted responses, oldest first
  flags_t   flag_st;        // predicted flag register
  req_t     offered;        // request currently on the input channel
  logic     idle_on;        // random idling enabled on both sides
  int       errors;
  int       responses_seen;
  int       idle_cycles;

  // Gap lengths: nine times in ten a short one, else a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Operands lean toward the corners where carry, overflow and zero change.
  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] corner[6];
    corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
    if ($urandom_range(0, 3) == 0)
      return corner[$urandom_range(0, 5)];
    return DATA_W'($urandom);
  endfunction

  // Predicts the response to one request and advances the flag register. Add and
  // subtract share one adder; for subtraction b is inverted and the carry out is
  // inverted again so that C reads as borrow. Overflow uses the adder's own b for
  // the arithmetic kinds and plain b for the rest.
  function automatic alu_out_t alu_predict(req_t rq);
    alu_out_t          o;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic              cin;
    logic              cy;
    logic              is_sub;
    o = '0;
    a = rq.operand_a;
    b = rq.operand_b;
    r = '0;
    if (rq.kind <= KIND_XOR) begin
      cy = rq.clear_carry ? 1'b0 : flag_st.c;
      case (rq.kind)
        KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBC: begin
          is_sub = (rq.kind == KIND_SUB) || (rq.kind == KIND_SBC);
          if (is_sub)
            b = ~b;
          case (rq.kind)
            KIND_ADD: cin = 1'b0;
            KIND_ADC: cin = cy;
            KIND_SUB: cin = 1'b1;
            default:  cin = ~cy;
          endcase
          sum = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
          r = sum[DATA_W-1:0];
          cy = is_sub ? ~sum[DATA_W] : sum[DATA_W];
        end
        KIND_RSUB: r = b - a;
        KIND_AND:  r = a & b;
        KIND_OR:   r = a | b;
        default:   r = a ^ b;
      endcase
      flag_st.n = r[DATA_W-1];
      flag_st.z = (r == '0);
      flag_st.v = (a[DATA_W-1] ^ r[DATA_W-1]) & (b[DATA_W-1] ^ r[DATA_W-1]);
      flag_st.c = cy;
    end else if (rq.kind == KIND_TEST) begin
      // The test kind reads the flags and leaves them alone.
      case (rq.condition)
        COND_AL, COND_AL_B, COND_AL_C: o.taken = 1'b1;
        COND_HI: o.taken = !flag_st.c && !flag_st.z;
        COND_LS: o.taken = flag_st.c || flag_st.z;
        COND_HS: o.taken = !flag_st.c;
        COND_LO: o.taken = flag_st.c;
        COND_EQ: o.taken = flag_st.z;
        COND_NE: o.taken = !flag_st.z;
        COND_GE: o.taken = (flag_st.n == flag_st.v);
        COND_LT: o.taken = (flag_st.n != flag_st.v);
        COND_GT: o.taken = !flag_st.z && (flag_st.n == flag_st.v);
        COND_LE: o.taken = flag_st.z || (flag_st.n != flag_st.v);
        default: o.taken = 1'b0;
      endcase
    end
    o.result = r;
    o.n = flag_st.n;
    o.z = flag_st.z;
    o.v = flag_st.v;
    o.c = flag_st.c;
    return o;
  endfunction

  function automatic void add_req(logic [3:0] kind, logic [DATA_W-1:0] a,
                                  logic [DATA_W-1:0] b, logic [3:0] cond, logic clr);
    req_t rq;
    rq.kind = kind;
    rq.operand_a = a;
    rq.operand_b = b;
    rq.condition = cond;
    rq.clear_carry = clr;
    req_q.push_back(rq);
  endfunction

  // Most random traffic is an ALU operation followed by zero to two condition tests,
  // the way branches follow compares in real code. The rest is noise: tests with no
  // fresh flags and the no-operation kinds. Returns how many of the pushed requests
  // do real work.
  function automatic int push_random_group();
    int pick;
    int tests;
    int worked;
    pick = $urandom_range(0, 9);
    worked = 0;
    if (pick < 7) begin
      add_req(kind_t'($urandom_range(KIND_ADD, KIND_XOR)), pick_operand(), pick_operand(),
              4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      worked = 1;
      tests = $urandom_range(0, 2);
      for (int i = 0; i < tests; i++)
        add_req(KIND_TEST, pick_operand(), pick_operand(), 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)));
      worked += tests;
    end else if (pick < 9) begin
      add_req(KIND_TEST, pick_operand(), pick_operand(), 4'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)));
      worked = 1;
    end else begin
      add_req(4'($urandom_range(KIND_NOP_LO, KIND_NOP_HI)), pick_operand(),
              pick_operand(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    end
    return worked;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] exp_val,
                             logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Driver. At each edge it first retires the request that was just accepted by running
  // it through the predictor, then decides whether the channel carries a new request,
  // an idle cycle, or keeps holding the current one.
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
      flag_st = '0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_q.push_back(alu_predict(offered));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          in_if.valid <= 1'b0;
          gap_left--;
        end else if (req_q.size() > 0) begin
          offered = req_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.kind <= offered.kind;
          in_if.operand_a <= offered.operand_a;
          in_if.operand_b <= offered.operand_b;
          in_if.condition <= offered.condition;
          in_if.clear_carry <= offered.clear_carry;
          // A gap, when drawn, opens after this request has gone.
          if (idle_on && $urandom_range(0, 4) == 0)
            gap_left = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Checks each accepted response against the oldest prediction, then sets
  // ready for the next edge. The long hold-off starts once, at a fixed response count,
  // while the driver keeps offering requests behind it.
  int stall_left;
  int hold_left;
  alu_out_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: response with nothing expected, result %h", $time, out_if.result);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("result", want.result, out_if.result);
          check_field("neg_flag", DATA_W'(want.n), DATA_W'(out_if.neg_flag));
          check_field("zero_flag", DATA_W'(want.z), DATA_W'(out_if.zero_flag));
          check_field("ovf_flag", DATA_W'(want.v), DATA_W'(out_if.ovf_flag));
          check_field("carry_flag", DATA_W'(want.c), DATA_W'(out_if.carry_flag));
          check_field("taken", DATA_W'(want.taken), DATA_W'(out_if.taken));
        end
        responses_seen++;
        if (responses_seen == HOLD_AT)
          hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Cycles in which neither channel moves a request or a response.
  always @(posedge clk) begin
    if (!rst_n)
      idle_cycles <= 0;
    else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    $display("tb_alu_with_flags_and_branch_test failed");
    $finish;
  end

  int worked;
  initial begin
    rst_n = 1'b0;
    idle_on = 1'b1;
    errors = 0;
    responses_seen = 0;
    idle_cycles = 0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_ADD;
    in_if.operand_a = '0;
    in_if.operand_b = '0;
    in_if.condition = COND_AL;
    in_if.clear_carry = 1'b0;
    out_if.ready = 1'b0;

    // Directed part. Most ALU operations are followed by tests that read the flags they
    // left, so every condition sees a state where its answer is interesting.
    add_req(KIND_ADD, 16'h0000, 16'h0000, COND_AL, 1'b0);       // zero result
    add_req(KIND_TEST, 16'hFFFF, 16'hFFFF, COND_EQ, 1'b1);      // clear_carry ignored
    add_req(KIND_ADD, 16'hFFFF, 16'h0001, COND_AL, 1'b0);       // carry out, zero
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_LS, 1'b0);
    add_req(KIND_ADC, 16'h7FFF, 16'h0000, COND_AL, 1'b0);       // carry in overflows
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_GE, 1'b0);
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_LT, 1'b0);
    add_req(KIND_SUB, 16'h0000, 16'h0001, COND_AL, 1'b0);       // borrow
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_LO, 1'b0);
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_HS, 1'b1);
    add_req(KIND_SBC, 16'h0000, 16'h0000, COND_AL, 1'b0);       // borrow in
    add_req(KIND_SBC, 16'h0005, 16'h0003, COND_AL, 1'b1);       // borrow cleared first
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_HI, 1'b0);
    add_req(KIND_SUB, 16'h8000, 16'h0001, COND_AL, 1'b0);       // signed overflow
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_GT, 1'b0);
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_LE, 1'b0);
    add_req(KIND_RSUB, 16'h0001, 16'h0000, COND_AL, 1'b0);      // carry kept
    add_req(KIND_AND, 16'hFFFF, 16'hAAAA, COND_AL, 1'b0);
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_NE, 1'b0);
    add_req(KIND_OR, 16'h0000, 16'h0000, COND_AL, 1'b1);
    add_req(KIND_XOR, 16'hFFFF, 16'h5555, COND_AL, 1'b0);
    add_req(KIND_NOP_HI, 16'hFFFF, 16'hFFFF, COND_NEVER_HI, 1'b1);  // no operation
    add_req(KIND_NOP_LO, 16'h1234, 16'h5678, COND_AL, 1'b0);
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_AL_B, 1'b0);
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_AL_C, 1'b0);
    add_req(KIND_TEST, 16'h0000, 16'h0000, COND_NEVER_LO, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Three random phases: idling on, idling off, idling on again. The long hold-off
    // lands in the second phase, where the driver never pauses on its own.
    for (int phase = 0; phase < 3; phase++) begin
      while (req_q.size() != 0)
        @(posedge clk);
      @(negedge clk);
      idle_on <= (phase != 1);
      worked = 0;
      while (worked < PHASE_ITEMS)
        worked += push_random_group();
    end

    while (req_q.size() != 0 || in_if.valid)
      @(posedge clk);
    while (expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("tb_alu_with_flags_and_branch_test passed");
    else
      $display("tb_alu_with_flags_and_branch_test failed");
    $finish;
  end

endmodule
